### design/seo_pkg.sv
package seo_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  localparam int PIX_W  = 12;
  localparam int G_W    = 32;
  localparam int IN_DW  = 2 * PIX_W + 5 * G_W;
  localparam int OUT_DW = 2 * G_W;

  localparam logic [PIX_W-1:0] CMASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);

  // Hessian entries are scaled so the largest magnitude has its msb here
  localparam int SC_MSB = 28;
  localparam int SC_W   = SC_MSB + 2;
  localparam int H_W    = SC_W + 1;
  localparam int HH_W   = 2 * (H_W - 1);
  localparam int X_W    = HH_W + 1;

  localparam int SQ_STEPS = 31;
  localparam int SQ_IN_W  = 2 * SQ_STEPS;
  localparam int SQ_REM_W = SQ_STEPS + 2;

  localparam int NS_W  = SQ_STEPS + 3;
  localparam int NM_W  = 14;
  localparam int N_W   = NM_W + 1;

  localparam int NN_W  = 2 * N_W;
  localparam int GN_W  = G_W + N_W;
  localparam int NUM_W = GN_W + 1;
  localparam int T_W   = G_W + NN_W;
  localparam int DEN_W = 64;

  localparam int NUMM_W = NUM_W - 1;
  localparam int P_W    = NUMM_W + NM_W;
  localparam int D_W    = DEN_W - 2;
  localparam int DN_W   = P_W + FRAC_BITS + 2;
  localparam int Q_W    = 40;
  localparam int REM_W  = D_W + 1;
  localparam int QO_W   = Q_W + 1;
  localparam int DIV_LAT = Q_W + 1;

  localparam int SUM_W  = 43;

  typedef struct packed {
    logic [PIX_W-1:0]      col;
    logic [PIX_W-1:0]      row;
    logic signed [G_W-1:0] gx;
    logic signed [G_W-1:0] gy;
    logic signed [G_W-1:0] gxx;
    logic signed [G_W-1:0] gyy;
    logic signed [G_W-1:0] gxy;
  } pt_t;

  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic             den0;
    logic             neg_x;
    logic             neg_y;
    logic [D_W-1:0]   d;
    logic [P_W-1:0]   px;
    logic [P_W-1:0]   py;
  } prj_t;

endpackage

### design/seo_isqrt.sv
module seo_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [seo_pkg::SQ_IN_W-1:0]   x,
  output logic [seo_pkg::SQ_STEPS-1:0]  root
);
  import seo_pkg::*;

  logic [SQ_REM_W-1:0] rem_r  [SQ_STEPS];
  logic [SQ_STEPS-1:0] root_r [SQ_STEPS];
  logic [SQ_IN_W-1:0]  xs_r   [SQ_STEPS];

  genvar i;
  for (i = 0; i < SQ_STEPS; i++) begin : g_step
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_STEPS-1:0] root_in;
    logic [SQ_IN_W-1:0]  xs_in;
    logic [SQ_REM_W+1:0] cand;
    logic [SQ_REM_W+1:0] trial;
    logic                ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign xs_in   = x;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign xs_in   = xs_r[i-1];
    end

    assign cand  = {rem_in, xs_in[SQ_IN_W-1 -: 2]};
    assign trial = (SQ_REM_W+2)'({root_in, 2'b01});
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? SQ_REM_W'(cand - trial) : SQ_REM_W'(cand);
        root_r[i] <= {root_in[SQ_STEPS-2:0], ge};
        xs_r[i]   <= {xs_in[SQ_IN_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[SQ_STEPS-1];

endmodule

### design/seo_eig.sv
module seo_eig (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  seo_pkg::pt_t                   in_pt,
  output logic                           out_vld,
  output seo_pkg::pt_t                   out_pt,
  output logic signed [seo_pkg::N_W-1:0] out_ny,
  output logic signed [seo_pkg::N_W-1:0] out_nx
);
  import seo_pkg::*;

  typedef struct packed {
    pt_t                    pt;
    logic signed [H_W-1:0]  h;
    logic signed [SC_W-1:0] b;
    logic                   larger;
    logic                   mzero;
  } es_t;

  // stage 1: magnitudes and their maximum
  logic [G_W-1:0] ma, mb, mc, mx;
  logic           s1_vld_r;
  pt_t            s1_pt_r;
  logic [G_W-1:0] s1_ma_r, s1_mb_r, s1_mc_r, s1_m_r;

  assign ma = in_pt.gyy[G_W-1] ? G_W'(-in_pt.gyy) : G_W'(in_pt.gyy);
  assign mb = in_pt.gxy[G_W-1] ? G_W'(-in_pt.gxy) : G_W'(in_pt.gxy);
  assign mc = in_pt.gxx[G_W-1] ? G_W'(-in_pt.gxx) : G_W'(in_pt.gxx);

  always_comb begin
    mx = ma;
    if (mb > mx) mx = mb;
    if (mc > mx) mx = mc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pt_r <= in_pt;
      s1_ma_r <= ma;
      s1_mb_r <= mb;
      s1_mc_r <= mc;
      s1_m_r  <= mx;
    end
  end

  // stage 2: common power-of-two scaling
  function automatic logic signed [SC_W-1:0] scl(input logic [G_W-1:0] mg,
                                                 input logic neg, input logic up,
                                                 input logic [4:0] amt);
    logic [2*G_W-1:0] ext;
    logic [SC_W-2:0]  v;
    ext = up ? ({G_W'(0), mg} << amt) : (2*G_W)'(mg >> amt);
    v   = ext[SC_W-2:0];
    return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  logic [4:0] msb, amt;
  logic       up;

  always_comb begin
    msb = '0;
    for (int i = 0; i < G_W; i++) begin
      if (s1_m_r[i]) msb = 5'(i);
    end
  end

  assign up  = msb < 5'(SC_MSB);
  assign amt = up ? 5'(SC_MSB) - msb : msb - 5'(SC_MSB);

  logic                   s2_vld_r;
  pt_t                    s2_pt_r;
  logic signed [SC_W-1:0] s2_a_r, s2_b_r, s2_c_r;
  logic                   s2_mzero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pt_r    <= s1_pt_r;
      s2_a_r     <= scl(s1_ma_r, s1_pt_r.gyy[G_W-1], up, amt);
      s2_b_r     <= scl(s1_mb_r, s1_pt_r.gxy[G_W-1], up, amt);
      s2_c_r     <= scl(s1_mc_r, s1_pt_r.gxx[G_W-1], up, amt);
      s2_mzero_r <= s1_m_r == '0;
    end
  end

  // stage 3: difference, sum and branch choice
  logic signed [H_W-1:0] h, s;
  logic                  s3_vld_r;
  es_t                   s3_r;

  assign h = H_W'(s2_a_r) - H_W'(s2_c_r);
  assign s = H_W'(s2_a_r) + H_W'(s2_c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.pt     <= s2_pt_r;
      s3_r.h      <= h;
      s3_r.b      <= s2_b_r;
      s3_r.larger <= !s[H_W-1] && (s != '0 || !h[H_W-1]);
      s3_r.mzero  <= s2_mzero_r;
    end
  end

  // stage 4: squares
  logic signed [2*H_W-1:0]  hh_full;
  logic signed [2*SC_W-1:0] bb_full;
  logic                     s4_vld_r;
  es_t                      s4_r;
  logic [HH_W-1:0]          s4_hh_r, s4_bb4_r;

  assign hh_full = s3_r.h * s3_r.h;
  assign bb_full = s3_r.b * s3_r.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r     <= s3_r;
      s4_hh_r  <= hh_full[HH_W-1:0];
      s4_bb4_r <= {bb_full[HH_W-3:0], 2'b00};
    end
  end

  // stage 5: radicand
  logic           s5_vld_r;
  es_t            s5_r;
  logic [X_W-1:0] s5_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r   <= s4_r;
      s5_x_r <= X_W'(s4_hh_r) + X_W'(s4_bb4_r);
    end
  end

  // square root, one result bit per stage
  logic [SQ_STEPS-1:0] root;

  seo_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .x    (SQ_IN_W'(s5_x_r)),
    .root (root)
  );

  es_t  dl_r [SQ_STEPS];
  logic dv_r [SQ_STEPS];

  genvar g;
  for (g = 0; g < SQ_STEPS; g++) begin : g_dly
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[g] <= 1'b0;
        end else if (en) begin
          dv_r[g] <= s5_vld_r;
        end
      end
      always_ff @(posedge clk) begin
        if (en) dl_r[g] <= s5_r;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[g] <= 1'b0;
        end else if (en) begin
          dv_r[g] <= dv_r[g-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) dl_r[g] <= dl_r[g-1];
      end
    end
  end

  // eigenvector selection
  es_t                    sq;
  logic signed [NS_W-1:0] hx, rx, b2, ny_nxt, nx_nxt;
  logic                   sel_vld_r;
  pt_t                    sel_pt_r;
  logic signed [NS_W-1:0] sel_ny_r, sel_nx_r;

  assign sq = dl_r[SQ_STEPS-1];
  assign hx = NS_W'(sq.h);
  assign rx = $signed(NS_W'(root));
  assign b2 = NS_W'(sq.b) <<< 1;

  always_comb begin
    if (sq.mzero || root == '0) begin
      ny_nxt = NS_W'(1);
      nx_nxt = '0;
    end else if (sq.larger) begin
      if (!sq.h[H_W-1]) begin
        ny_nxt = hx + rx;
        nx_nxt = b2;
      end else begin
        ny_nxt = b2;
        nx_nxt = rx - hx;
      end
    end else begin
      if (sq.h[H_W-1] || sq.h == '0) begin
        ny_nxt = hx - rx;
        nx_nxt = b2;
      end else begin
        ny_nxt = b2;
        nx_nxt = -hx - rx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
    end else if (en) begin
      sel_vld_r <= dv_r[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_pt_r <= sq.pt;
      sel_ny_r <= ny_nxt;
      sel_nx_r <= nx_nxt;
    end
  end

  // shrink both components below 2^NM_W
  logic [NS_W-2:0] nym, nxm, nm;
  logic [5:0]      nmsb, k;
  logic [NS_W-2:0] nys, nxs;

  assign nym = sel_ny_r[NS_W-1] ? (NS_W-1)'(-sel_ny_r) : (NS_W-1)'(sel_ny_r);
  assign nxm = sel_nx_r[NS_W-1] ? (NS_W-1)'(-sel_nx_r) : (NS_W-1)'(sel_nx_r);
  assign nm  = nym > nxm ? nym : nxm;

  always_comb begin
    nmsb = '0;
    for (int i = 0; i < NS_W - 1; i++) begin
      if (nm[i]) nmsb = 6'(i);
    end
  end

  assign k   = nmsb > 6'(NM_W - 1) ? nmsb - 6'(NM_W - 1) : '0;
  assign nys = nym >> k;
  assign nxs = nxm >> k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= sel_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pt <= sel_pt_r;
      out_ny <= sel_ny_r[NS_W-1] ? -$signed({1'b0, nys[NM_W-1:0]})
                                 : $signed({1'b0, nys[NM_W-1:0]});
      out_nx <= sel_nx_r[NS_W-1] ? -$signed({1'b0, nxs[NM_W-1:0]})
                                 : $signed({1'b0, nxs[NM_W-1:0]});
    end
  end

endmodule

### design/seo_proj.sv
module seo_proj (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  seo_pkg::pt_t                   in_pt,
  input  logic signed [seo_pkg::N_W-1:0] in_ny,
  input  logic signed [seo_pkg::N_W-1:0] in_nx,
  output logic                           out_vld,
  output seo_pkg::prj_t                  out_prj
);
  import seo_pkg::*;

  // P1: direction products
  logic                    p1_vld_r;
  pt_t                     p1_pt_r;
  logic signed [N_W-1:0]   p1_ny_r, p1_nx_r;
  logic signed [NN_W-1:0]  p1_nxx_r, p1_nxy_r, p1_nyy_r;
  logic signed [GN_W-1:0]  p1_gxn_r, p1_gyn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_pt_r  <= in_pt;
      p1_ny_r  <= in_ny;
      p1_nx_r  <= in_nx;
      p1_nxx_r <= in_nx * in_nx;
      p1_nxy_r <= in_nx * in_ny;
      p1_nyy_r <= in_ny * in_ny;
      p1_gxn_r <= in_pt.gx * in_nx;
      p1_gyn_r <= in_pt.gy * in_ny;
    end
  end

  // P2: curvature terms and numerator
  logic                    p2_vld_r;
  logic [PIX_W-1:0]        p2_col_r, p2_row_r;
  logic signed [N_W-1:0]   p2_ny_r, p2_nx_r;
  logic signed [T_W-1:0]   p2_tx_r, p2_txy_r, p2_ty_r;
  logic signed [NUM_W-1:0] p2_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_col_r <= p1_pt_r.col;
      p2_row_r <= p1_pt_r.row;
      p2_ny_r  <= p1_ny_r;
      p2_nx_r  <= p1_nx_r;
      p2_tx_r  <= p1_pt_r.gxx * p1_nxx_r;
      p2_txy_r <= p1_pt_r.gxy * p1_nxy_r;
      p2_ty_r  <= p1_pt_r.gyy * p1_nyy_r;
      p2_num_r <= NUM_W'(p1_gxn_r) + NUM_W'(p1_gyn_r);
    end
  end

  // P3: denominator
  logic                    p3_vld_r;
  logic [PIX_W-1:0]        p3_col_r, p3_row_r;
  logic signed [N_W-1:0]   p3_ny_r, p3_nx_r;
  logic signed [NUM_W-1:0] p3_num_r;
  logic signed [DEN_W-1:0] p3_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_col_r <= p2_col_r;
      p3_row_r <= p2_row_r;
      p3_ny_r  <= p2_ny_r;
      p3_nx_r  <= p2_nx_r;
      p3_num_r <= p2_num_r;
      p3_den_r <= DEN_W'(p2_tx_r) + (DEN_W'(p2_txy_r) <<< 1) + DEN_W'(p2_ty_r);
    end
  end

  // P4: magnitudes and result signs
  logic                   p4_vld_r;
  logic [PIX_W-1:0]       p4_col_r, p4_row_r;
  logic [NUMM_W-1:0]      p4_numm_r;
  logic [NM_W-1:0]        p4_nym_r, p4_nxm_r;
  logic [D_W-1:0]         p4_d_r;
  logic                   p4_den0_r, p4_negx_r, p4_negy_r;
  logic                   sgn;

  assign sgn = p3_num_r[NUM_W-1] ^ p3_den_r[DEN_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else if (en) begin
      p4_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_col_r  <= p3_col_r;
      p4_row_r  <= p3_row_r;
      p4_numm_r <= p3_num_r[NUM_W-1] ? NUMM_W'(-p3_num_r) : NUMM_W'(p3_num_r);
      p4_nym_r  <= p3_ny_r[N_W-1] ? NM_W'(-p3_ny_r) : NM_W'(p3_ny_r);
      p4_nxm_r  <= p3_nx_r[N_W-1] ? NM_W'(-p3_nx_r) : NM_W'(p3_nx_r);
      p4_d_r    <= p3_den_r[DEN_W-1] ? D_W'(-p3_den_r) : D_W'(p3_den_r);
      p4_den0_r <= p3_den_r == '0;
      p4_negx_r <= !(sgn ^ p3_nx_r[N_W-1]);
      p4_negy_r <= !(sgn ^ p3_ny_r[N_W-1]);
    end
  end

  // P5: dividends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_prj.col   <= p4_col_r;
      out_prj.row   <= p4_row_r;
      out_prj.den0  <= p4_den0_r;
      out_prj.neg_x <= p4_negx_r;
      out_prj.neg_y <= p4_negy_r;
      out_prj.d     <= p4_d_r;
      out_prj.px    <= p4_numm_r * p4_nxm_r;
      out_prj.py    <= p4_numm_r * p4_nym_r;
    end
  end

endmodule

### design/seo_div.sv
module seo_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [seo_pkg::P_W-1:0]     p,
  input  logic [seo_pkg::D_W-1:0]     d,
  output logic [seo_pkg::QO_W-1:0]    q
);
  import seo_pkg::*;

  // rounded quotient (p*2^(F+1) + d) / 2d, clamped at 2^Q_W
  logic [DN_W-1:0]  n;
  logic [DN_W-42:0] n_hi;

  assign n    = (DN_W'(p) << (FRAC_BITS + 1)) + DN_W'(d);
  assign n_hi = n[DN_W-1:Q_W+1];

  logic             d0_ovf_r;
  logic [REM_W-1:0] d0_rem_r;
  logic [Q_W-1:0]   d0_lo_r;
  logic [REM_W-1:0] d0_d2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d0_ovf_r <= 64'(n_hi) >= 64'(d);
      d0_rem_r <= REM_W'(n[DN_W-1:Q_W]);
      d0_lo_r  <= n[Q_W-1:0];
      d0_d2_r  <= {d, 1'b0};
    end
  end

  logic             ovf_r [Q_W];
  logic [REM_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   lo_r  [Q_W];
  logic [REM_W-1:0] d2_r  [Q_W];
  logic [Q_W-1:0]   qs_r  [Q_W];

  genvar i;
  for (i = 0; i < Q_W; i++) begin : g_step
    logic             ovf_in;
    logic [REM_W-1:0] rem_in;
    logic [Q_W-1:0]   lo_in;
    logic [REM_W-1:0] d2_in;
    logic [Q_W-1:0]   qs_in;
    logic [REM_W:0]   cand;
    logic             ge;

    if (i == 0) begin : g_first
      assign ovf_in = d0_ovf_r;
      assign rem_in = d0_rem_r;
      assign lo_in  = d0_lo_r;
      assign d2_in  = d0_d2_r;
      assign qs_in  = '0;
    end else begin : g_next
      assign ovf_in = ovf_r[i-1];
      assign rem_in = rem_r[i-1];
      assign lo_in  = lo_r[i-1];
      assign d2_in  = d2_r[i-1];
      assign qs_in  = qs_r[i-1];
    end

    assign cand = {rem_in, lo_in[Q_W-1]};
    assign ge   = cand >= (REM_W+1)'(d2_in);

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[i] <= ovf_in;
        rem_r[i] <= ge ? REM_W'(cand - (REM_W+1)'(d2_in)) : REM_W'(cand);
        lo_r[i]  <= {lo_in[Q_W-2:0], 1'b0};
        d2_r[i]  <= d2_in;
        qs_r[i]  <= {qs_in[Q_W-2:0], ge};
      end
    end
  end

  assign q = ovf_r[Q_W-1] ? {1'b1, {Q_W{1'b0}}} : {1'b0, qs_r[Q_W-1]};

endmodule

### design/subpixel_edge_offset.sv
// Hessian-based subpixel edge offset. Takes one edge pixel per cycle with its
// gradient-magnitude derivatives and returns the refined position in signed
// Q15.16 (saturated), with out_tuser low when the step denominator is zero and
// the pixel centre is returned. Fully pipelined: one request per cycle, with
// the pipeline depth set mainly by the 31-stage square root and the 41-stage
// divider. A stall on the output halts the whole pipeline; no request is lost
// or repeated.
module subpixel_edge_offset (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel_col, pixel_row, deriv_x, deriv_y, deriv_xx, deriv_yy, deriv_xy
  input  logic [seo_pkg::IN_DW-1:0]   in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // sub_x, sub_y
  output logic [seo_pkg::OUT_DW-1:0]  out_tdata,
  // offset_valid
  output logic [0:0]                  out_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready
);
  import seo_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic             den0;
    logic             neg_x;
    logic             neg_y;
  } side_t;

  logic en;
  pt_t  in_pt;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign in_pt.col = in_tdata[PIX_W-1:0] & CMASK;
  assign in_pt.row = in_tdata[2*PIX_W-1:PIX_W] & CMASK;
  assign in_pt.gx  = in_tdata[2*PIX_W+G_W-1:2*PIX_W];
  assign in_pt.gy  = in_tdata[2*PIX_W+2*G_W-1:2*PIX_W+G_W];
  assign in_pt.gxx = in_tdata[2*PIX_W+3*G_W-1:2*PIX_W+2*G_W];
  assign in_pt.gyy = in_tdata[2*PIX_W+4*G_W-1:2*PIX_W+3*G_W];
  assign in_pt.gxy = in_tdata[2*PIX_W+5*G_W-1:2*PIX_W+4*G_W];

  logic                  eig_vld;
  pt_t                   eig_pt;
  logic signed [N_W-1:0] eig_ny, eig_nx;

  seo_eig u_eig (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_pt   (in_pt),
    .out_vld (eig_vld),
    .out_pt  (eig_pt),
    .out_ny  (eig_ny),
    .out_nx  (eig_nx)
  );

  logic prj_vld;
  prj_t prj;

  seo_proj u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (eig_vld),
    .in_pt   (eig_pt),
    .in_ny   (eig_ny),
    .in_nx   (eig_nx),
    .out_vld (prj_vld),
    .out_prj (prj)
  );

  logic [QO_W-1:0] qx, qy;

  seo_div u_div_x (
    .clk (clk),
    .en  (en),
    .p   (prj.px),
    .d   (prj.d),
    .q   (qx)
  );

  seo_div u_div_y (
    .clk (clk),
    .en  (en),
    .p   (prj.py),
    .d   (prj.d),
    .q   (qy)
  );

  side_t sd_r [DIV_LAT];
  logic  sv_r [DIV_LAT];

  genvar g;
  for (g = 0; g < DIV_LAT; g++) begin : g_side
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[g] <= 1'b0;
        end else if (en) begin
          sv_r[g] <= prj_vld;
        end
      end
      always_ff @(posedge clk) begin
        if (en) sd_r[g] <= '{prj.col, prj.row, prj.den0, prj.neg_x, prj.neg_y};
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[g] <= 1'b0;
        end else if (en) begin
          sv_r[g] <= sv_r[g-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) sd_r[g] <= sd_r[g-1];
      end
    end
  end

  function automatic logic [G_W-1:0] sat_pos(input logic [PIX_W-1:0] pix,
                                             input logic signed [QO_W:0] off);
    logic signed [SUM_W-1:0] v;
    v = $signed(SUM_W'(pix) << FRAC_BITS) + SUM_W'(off);
    if (v[SUM_W-1:G_W-1] != '0 && v[SUM_W-1:G_W-1] != '1) begin
      return v[SUM_W-1] ? {1'b1, {(G_W-1){1'b0}}} : {1'b0, {(G_W-1){1'b1}}};
    end
    return v[G_W-1:0];
  endfunction

  side_t                  sd;
  logic signed [QO_W:0]   ox, oy;

  assign sd = sd_r[DIV_LAT-1];
  assign ox = sd.den0 ? '0 : (sd.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
  assign oy = sd.den0 ? '0 : (sd.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= sv_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {sat_pos(sd.row, oy), sat_pos(sd.col, ox)};
      out_tuser <= !sd.den0;
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import seo_pkg::*;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        ok;
  } edge_pos_t;

  typedef struct {
    logic [11:0] col, row;
    logic [31:0] gx, gy, gxx, gyy, gxy;
    bit          typed;
    edge_pos_t   want;
  } vec_t;

  localparam longint OFF_CLAMP = 64'sd1 << 40;
  localparam int LIMIT_CYCLES = 600000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic [IN_DW-1:0]   in_tdata = '0;
  logic               in_tvalid = 0;
  logic               in_tready;
  logic [OUT_DW-1:0]  out_tdata;
  logic [0:0]         out_tuser;
  logic               out_tvalid;
  logic               out_tready = 0;

  subpixel_edge_offset dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  edge_pos_t pos_queue[$];
  vec_t      vecs[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_acc = 0;
  int        n_got = 0;
  int        n_flat = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  bit        hold_req = 0;
  bit        hold = 0;
  int        cycles = 0;

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint shr_tz(longint v, int k);
    logic [63:0] m;
    m = mag64(v) >> k;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint step_part(longint num, longint comp, longint den);
    logic [63:0]  p, d, q;
    logic [127:0] w, q128;
    bit           pos;
    if (num == 0 || comp == 0 || den == 0) return 0;
    p = mag64(num) * mag64(comp);
    d = mag64(den);
    w = ({64'd0, p} << (FRAC_BITS + 1)) + {64'd0, d};
    q128 = w / ({64'd0, d} << 1);
    q = (q128 > 128'(OFF_CLAMP)) ? 64'(OFF_CLAMP) : q128[63:0];
    pos = ((num < 0) != (comp < 0)) != (den < 0);
    return pos ? longint'(q) : -longint'(q);
  endfunction

  function automatic logic [31:0] sat_pos(logic [11:0] pix, longint off);
    longint v;
    v = (longint'(pix) <<< FRAC_BITS) + off;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic edge_pos_t refine_edge(logic [IN_DW-1:0] d);
    logic [11:0] col, row;
    longint gx, gy, gxx, gyy, gxy, ny, nx, num, den, a, b, c, h, s, r, oy, ox;
    logic [63:0] m, nm;
    int sh, k;
    edge_pos_t res;
    col = d[11:0] & CMASK;
    row = d[23:12] & CMASK;
    gx  = longint'($signed(d[55:24]));
    gy  = longint'($signed(d[87:56]));
    gxx = longint'($signed(d[119:88]));
    gyy = longint'($signed(d[151:120]));
    gxy = longint'($signed(d[183:152]));
    ny = 1; nx = 0; oy = 0; ox = 0;
    m = mag64(gyy);
    if (mag64(gxy) > m) m = mag64(gxy);
    if (mag64(gxx) > m) m = mag64(gxx);
    if (m != 0) begin
      sh = 0;
      while (m >= (64'd1 << 29)) begin m >>= 1; sh--; end
      while (m < (64'd1 << 28)) begin m <<= 1; sh++; end
      a = sh >= 0 ? gyy <<< sh : shr_tz(gyy, -sh);
      b = sh >= 0 ? gxy <<< sh : shr_tz(gxy, -sh);
      c = sh >= 0 ? gxx <<< sh : shr_tz(gxx, -sh);
      h = a - c;
      s = a + c;
      r = longint'(isqrt(64'(h * h) + 64'(4 * b * b)));
      if (r != 0) begin
        if (s > 0 || (s == 0 && h >= 0)) begin
          if (h >= 0) begin ny = h + r; nx = 2 * b; end
          else begin ny = 2 * b; nx = r - h; end
        end else begin
          if (h <= 0) begin ny = h - r; nx = 2 * b; end
          else begin ny = 2 * b; nx = -h - r; end
        end
        nm = mag64(ny) > mag64(nx) ? mag64(ny) : mag64(nx);
        k = 0;
        while ((nm >> k) >= (64'd1 << 14)) k++;
        ny = shr_tz(ny, k);
        nx = shr_tz(nx, k);
      end
    end
    num = gx * nx + gy * ny;
    den = gxx * nx * nx + 2 * gxy * nx * ny + gyy * ny * ny;
    res.ok = den != 0;
    if (res.ok) begin
      oy = step_part(num, ny, den);
      ox = step_part(num, nx, den);
    end
    res.sx = sat_pos(col, ox);
    res.sy = sat_pos(row, oy);
    return res;
  endfunction

  function automatic logic [IN_DW-1:0] pack_vec(vec_t v);
    return {v.gxy, v.gyy, v.gxx, v.gy, v.gx, v.row, v.col};
  endfunction

  function automatic logic [31:0] rnd_deriv();
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = 32'($urandom_range(0, 1 << 20)) - 32'd524288;
      2: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(1)) v = -v;
      end
      3: v = 32'($urandom_range(0, 1 << 16)) - 32'd32768;
      default: v = $urandom_range(1) ? 32'd0 : 32'h8000_0000;
    endcase
    return v;
  endfunction

  function automatic vec_t rnd_vec();
    vec_t v;
    v.col = $urandom_range(4095);
    v.row = $urandom_range(4095);
    v.gx  = rnd_deriv();
    v.gy  = rnd_deriv();
    v.gxx = rnd_deriv();
    v.gyy = rnd_deriv();
    v.gxy = rnd_deriv();
    case ($urandom_range(9))
      0: v.gyy = -v.gxx;
      1: begin v.gyy = v.gxx; v.gxy = 0; end
      2: v.gx = 0;
      default: ;
    endcase
    v.typed = 0;
    return v;
  endfunction

  function automatic vec_t mk(logic [11:0] col, row, logic [31:0] gx, gy, gxx, gyy, gxy);
    vec_t v;
    v.col = col; v.row = row;
    v.gx = gx; v.gy = gy; v.gxx = gxx; v.gyy = gyy; v.gxy = gxy;
    v.typed = 0;
    return v;
  endfunction

  function automatic vec_t mk_flat(logic [11:0] col, row);
    vec_t v;
    v = mk(col, row, 0, 0, 0, 0, 0);
    v.typed = 1;
    v.want.sx = {4'd0, col, 16'd0};
    v.want.sy = {4'd0, row, 16'd0};
    v.want.ok = 0;
    return v;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_got);
  endtask

  task automatic send(vec_t v);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tdata  <= pack_vec(v);
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pos_queue.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      automatic int idx = n_acc;
      automatic edge_pos_t e = refine_edge(in_tdata);
      if (idx < vecs.size() && vecs[idx].typed) e = vecs[idx].want;
      pos_queue.push_back(e);
      n_acc++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pos_queue.size() == 0) begin
        report("unexpected result", out_tdata[31:0], 32'd0);
      end else begin
        automatic edge_pos_t e = pos_queue.pop_front();
        if (out_tdata[31:0] !== e.sx) report("sub_x", out_tdata[31:0], e.sx);
        if (out_tdata[63:32] !== e.sy) report("sub_y", out_tdata[63:32], e.sy);
        if (out_tuser[0] !== e.ok) report("offset_valid", out_tuser[0], e.ok);
        if (!e.ok) n_flat++;
      end
      n_got++;
    end
  end

  always @(posedge clk) begin
    out_tready <= !hold && ($urandom_range(99) >= recv_idle);
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold = 1;
    repeat (400) @(posedge clk);
    hold = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    vecs.push_back(mk_flat(0, 0));
    vecs.push_back(mk_flat(4095, 4095));
    vecs.push_back(mk_flat(4095, 0));
    vecs.push_back(mk(10, 20, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff));
    vecs.push_back(mk(10, 20, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000));
    vecs.push_back(mk(100, 200, 32'h0001_0000, 32'h0002_0000, 32'hfffe_0000,
                      32'h0002_0000, 32'h0000_8000));
    vecs.push_back(mk(100, 200, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                      32'h0003_0000, 0));
    vecs.push_back(mk(5, 5, 32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0001_0000));
    vecs.push_back(mk(5, 5, 32'h7fff_ffff, 32'h8000_0000, 1, 1, 0));
    vecs.push_back(mk(4095, 4095, 32'h8000_0000, 32'h8000_0000, 0, 1, 0));
    vecs.push_back(mk(4095, 4095, 32'h7fff_ffff, 32'h7fff_ffff, 0, -1, 0));
    vecs.push_back(mk(0, 0, 32'h7fff_ffff, 32'h7fff_ffff, -1, 0, 0));
    vecs.push_back(mk(7, 9, 32'h0000_4000, 32'hffff_c000, 32'hfff0_0000,
                      32'h0010_0000, 32'h0008_0000));
    vecs.push_back(mk(7, 9, 32'h0000_4000, 32'hffff_c000, 32'h0010_0000,
                      32'hfff0_0000, 32'hfff8_0000));
    vecs.push_back(mk(33, 44, 32'h0000_1000, 0, 32'hffff_0000, 32'hffff_0000, 0));
    vecs.push_back(mk(33, 44, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0001_8000));
    vecs.push_back(mk(1, 2, 32'h1234_5678, 32'h8765_4321, 32'h0000_0003,
                      32'hffff_fffd, 32'h0000_0002));
    for (int i = 0; i < 1700; i++) vecs.push_back(rnd_vec());

    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 9 : ph == 1 ? 79 : 0;
      recv_idle = ph == 0 ? 79 : ph == 1 ? 9 : 0;
      if (ph == 2) hold_req = 1;
      while (n_sent < vecs.size() && n_sent < (ph + 1) * 580) send(vecs[n_sent]);
      drain();
    end
    repeat (200) @(posedge clk);
    $display("%0d edge points sent, %0d refined positions checked, %0d with zero step",
             n_sent, n_got, n_flat);
    $display("covered three idle mixes and a long output stall; %0d mismatches", errors);
    if (errors == 0 && pos_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/seo_pkg.sv
design/seo_isqrt.sv
design/seo_eig.sv
design/seo_proj.sv
design/seo_div.sv
design/subpixel_edge_offset.sv
bench/testbench.sv
